// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/bba_pkg.sv =====
// Shared constants, types and helpers of the buddy block allocator
package bba_pkg;

    localparam int TOTAL_UNITS = 1024;
    localparam int POOL_LG     = $clog2(TOTAL_UNITS + 1) - 1;
    localparam int POOL_UNITS  = 1 << POOL_LG;
    localparam int ADDR_W      = POOL_LG;
    localparam int WALK_W      = POOL_LG + 1;
    localparam int LG_W        = 4;
    localparam int SIZE_W      = 11;
    localparam int START_W     = 10;
    localparam int FRAG_W      = 10;
    localparam int OWNER_W     = 8;

    typedef struct packed {
        logic               head;
        logic               used;
        logic [OWNER_W-1:0] owner;
        logic [LG_W-1:0]    lg;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ROOM  = 2'd1,
        ST_NO_OWNER = 2'd2,
        ST_BAD_SIZE = 2'd3
    } status_t;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_SPLIT,
        S_MERGE_RD,
        S_MERGE_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        status_t            status;
        logic [START_W-1:0] block_start;
        logic [SIZE_W-1:0]  block_units;
        logic [FRAG_W-1:0]  fragment_units;
    } result_t;

    typedef struct packed {
        op_t                op;
        logic [OWNER_W-1:0] owner;
        logic [SIZE_W-1:0]  size;
    } cmd_t;

    function automatic logic [LG_W-1:0] ceil_lg(input logic [SIZE_W-1:0] s);
        logic [LG_W-1:0] r;
        r = LG_W'(POOL_LG);
        for (int n = POOL_LG; n >= 0; n--)
        begin
            if ((SIZE_W+1)'(1 << n) >= {1'b0, s})
            begin
                r = LG_W'(n);
            end
        end
        return r;
    endfunction

endpackage

// ===== design/bba_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read
module bba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/bba_ctrl.sv =====
// Sequencer that walks, splits and merges blocks in the block table
module bba_ctrl
    import bba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    output logic    cmd_ready,
    input  cmd_t    cmd,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    state_t state_reg, state_next;
    logic [ADDR_W-1:0]  clr_reg, clr_next;
    logic [WALK_W-1:0]  addr_reg, addr_next;
    logic [LG_W-1:0]    lg_reg, lg_next;
    logic [LG_W-1:0]    need_reg, need_next;
    cmd_t               cmd_reg, cmd_next;
    result_t            res_reg, res_next;

    logic               we;
    logic [ADDR_W-1:0]  waddr, raddr;
    entry_t             wdata, rdata;
    logic [ENTRY_W-1:0] rdata_raw;
    logic [ADDR_W-1:0]  buddy;
    logic [SIZE_W-1:0]  bsz;

    bba_ram #(.WIDTH(ENTRY_W), .DEPTH(POOL_UNITS)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata     = entry_t'(rdata_raw);
    assign buddy     = addr_reg[ADDR_W-1:0] ^ ADDR_W'(1 << lg_reg);
    assign bsz       = SIZE_W'(1) << rdata.lg;
    assign cmd_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        lg_reg   <= lg_next;
        need_reg <= need_next;
        cmd_reg  <= cmd_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        addr_next  = addr_reg;
        lg_next    = lg_reg;
        need_next  = need_reg;
        cmd_next   = cmd_reg;
        res_next   = res_reg;
        we         = 1'b0;
        waddr      = addr_reg[ADDR_W-1:0];
        wdata      = '0;
        raddr      = addr_reg[ADDR_W-1:0];
        unique case (state_reg)
            S_CLEAR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    wdata = '{head: 1'b1, used: 1'b0, owner: '0, lg: LG_W'(POOL_LG)};
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(POOL_UNITS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next  = cmd;
                    need_next = ceil_lg(cmd.size);
                    addr_next = '0;
                    if (cmd.op == OP_REQUEST &&
                        (cmd.size == '0 || cmd.size > SIZE_W'(POOL_UNITS)))
                    begin
                        res_next   = '{ST_BAD_SIZE, '0, '0, '0};
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK_RD;
                    end
                end
            end
            S_WALK_RD:
            begin
                if (addr_reg >= WALK_W'(POOL_UNITS))
                begin
                    res_next   = '{(cmd_reg.op == OP_REQUEST) ? ST_NO_ROOM : ST_NO_OWNER,
                                   '0, '0, '0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_WALK_CHK;
                end
            end
            S_WALK_CHK:
            begin
                lg_next = rdata.lg;
                if (cmd_reg.op == OP_REQUEST && !rdata.used && rdata.lg >= need_reg)
                begin
                    state_next = S_SPLIT;
                end
                else if (cmd_reg.op == OP_RELEASE && rdata.used &&
                         rdata.owner == cmd_reg.owner)
                begin
                    state_next = S_MERGE_RD;
                end
                else
                begin
                    addr_next  = addr_reg + WALK_W'(bsz);
                    state_next = S_WALK_RD;
                end
            end
            S_SPLIT:
            begin
                we = 1'b1;
                if (lg_reg > need_reg)
                begin
                    waddr   = addr_reg[ADDR_W-1:0] | ADDR_W'(1 << (lg_reg - 1'b1));
                    wdata   = '{head: 1'b1, used: 1'b0, owner: '0, lg: lg_reg - 1'b1};
                    lg_next = lg_reg - 1'b1;
                end
                else
                begin
                    wdata = '{head: 1'b1, used: 1'b1, owner: cmd_reg.owner, lg: need_reg};
                    res_next = '{ST_OK, addr_reg[START_W-1:0],
                                 SIZE_W'(1) << need_reg,
                                 FRAG_W'((SIZE_W'(1) << need_reg) - cmd_reg.size)};
                    state_next = S_DONE;
                end
            end
            S_MERGE_RD:
            begin
                raddr = buddy;
                if (lg_reg == LG_W'(POOL_LG))
                begin
                    we    = 1'b1;
                    wdata = '{head: 1'b1, used: 1'b0, owner: '0, lg: lg_reg};
                    res_next = '{ST_OK, addr_reg[START_W-1:0], SIZE_W'(1) << lg_reg, '0};
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MERGE_CHK;
                end
            end
            S_MERGE_CHK:
            begin
                we = 1'b1;
                if (rdata.head && !rdata.used && rdata.lg == lg_reg)
                begin
                    waddr      = addr_reg[ADDR_W-1:0] | buddy;
                    wdata      = '0;
                    addr_next  = WALK_W'(addr_reg[ADDR_W-1:0] & buddy);
                    lg_next    = lg_reg + 1'b1;
                    state_next = S_MERGE_RD;
                end
                else
                begin
                    wdata = '{head: 1'b1, used: 1'b0, owner: '0, lg: lg_reg};
                    res_next = '{ST_OK, addr_reg[START_W-1:0], SIZE_W'(1) << lg_reg, '0};
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/buddy_block_allocator.sv =====
// Buddy block allocator: stream ports, request unpacking and output register
//
// Slave channel s_axis carries one request per transfer: tuser is the operation
// (0 allocate, 1 release), tdata holds the owner byte and the size in units.
// Master channel m_axis returns exactly one result per request: status, block
// start, block size and internal fragmentation.
// After reset the block table is cleared one entry a cycle, with s_axis_tready
// low; the pool is then a single free block of 1024 units at 0.
// Each request walks the table block by block through one memory read port:
// each block visited passes a read state and a check state, each split step
// writes one entry, and each merge step reads the buddy and then checks it; a
// walk can visit up to 1024 single-unit blocks. One request is in flight at a time.
// The result sits in an output register; while the receiver stalls the next
// request is still taken and processed, and its result waits in the
// sequencer until the register frees.
module buddy_block_allocator
    import bba_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // owner_name[7:0], request_size[18:8], zero pad
    input  logic        s_axis_tuser,  // operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata   // status[1:0], block_start[11:2],
                                       // block_units[22:12], fragment_units[32:23], pad
);

    cmd_t    cmd;
    result_t res;
    logic    res_valid, res_ready;
    logic    m_valid_reg, m_valid_next;
    logic [39:0] m_data_reg, m_data_next;

    assign cmd = '{op: op_t'(s_axis_tuser), owner: s_axis_tdata[7:0],
                   size: s_axis_tdata[18:8]};

    bba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (s_axis_tvalid),
        .cmd_ready (s_axis_tready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {7'd0, res.fragment_units, res.block_units,
                            res.block_start, res.status};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== design/bba_checker.sv =====
// Port-level checks of the buddy block allocator and their binding
`include "assert_macros.svh"

module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    `BBA_ASSERT_NEXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `BBA_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `BBA_ASSERT_NOW(a_error_zero, m_axis_tvalid && m_axis_tdata[1:0] != 2'd0,
        m_axis_tdata[32:2] == 31'd0)
    `BBA_ASSERT_NOW(a_ok_sized, m_axis_tvalid && m_axis_tdata[1:0] == 2'd0,
        m_axis_tdata[22:12] != 11'd0)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
